// ----- hw/rtl/m4rm_pkg.sv -----
// ----------------------------------------------------------------------------
// m4rm_pkg
// Shared constants and types for the 4x4 row-times-matrix multiplier.
// ----------------------------------------------------------------------------
package m4rm_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;

  localparam int ELEM_W = 32;
  localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int PAIR_N = (DIM + 1) / 2;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + $clog2(DIM);
  localparam int SHR_W  = SUM_W - FRAC_BITS;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t vec_t [DIM];

  localparam elem_t ONE  = elem_t'(64'sd1 <<< FRAC_BITS);
  localparam elem_t EMAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t EMIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // per-stage advance enables, issued by the top level
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// ----- hw/rtl/m4rm_column.sv -----
// ----------------------------------------------------------------------------
// m4rm_column
// One output column: products, pair sums, final sum and shift, saturation.
// ----------------------------------------------------------------------------
module m4rm_column (
  input  logic                clk,
  input  m4rm_pkg::stage_en_t en,
  input  m4rm_pkg::vec_t      row,
  input  m4rm_pkg::vec_t      col,
  output m4rm_pkg::elem_t     prod,
  output logic                clip
);
  import m4rm_pkg::*;

  logic signed [PROD_W-1:0] prd  [DIM];
  logic signed [PAIR_W-1:0] pair [PAIR_N];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SHR_W-1:0]  shr;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int k = 0; k < DIM; k++) begin
        prd[k] <= row[k] * col[k];
      end
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int i = 0; i < PAIR_N; i++) begin
        if (2 * i + 1 < DIM) begin
          pair[i] <= PAIR_W'(prd[2*i]) + PAIR_W'(prd[2*i+1]);
        end else begin
          pair[i] <= PAIR_W'(prd[2*i]);
        end
      end
    end
  end

  // stage 3: full sum, floor shift
  always_comb begin
    sum = '0;
    for (int i = 0; i < PAIR_N; i++) begin
      sum = sum + SUM_W'(pair[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      shr <= SHR_W'(sum >>> FRAC_BITS);
    end
  end

  // stage 4: saturate
  always_ff @(posedge clk) begin
    if (en.s4) begin
      if (shr > SHR_W'(EMAX)) begin
        prod <= EMAX;
        clip <= 1'b1;
      end else if (shr < SHR_W'(EMIN)) begin
        prod <= EMIN;
        clip <= 1'b1;
      end else begin
        prod <= ELEM_W'(shr);
        clip <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/matrix4_row_multiply.sv -----
// ----------------------------------------------------------------------------
// matrix4_row_multiply
// Stores a 4x4 matrix M and returns rows of A * M in saturating Q16.16.
// ----------------------------------------------------------------------------
// A multiply request gives its result once it has passed the stages below.
// One request per cycle while req_stall is low; loads give no result.
// The four register stages (multiply, pair add, sum and shift, saturate)
// stall only where the stage ahead is full and held by rsp_stall.
// Reset (synchronous rst): M returns to identity, all stage valids clear.
// ----------------------------------------------------------------------------
module matrix4_row_multiply (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  logic            mode,
  input  logic [1:0]      row_index,
  input  m4rm_pkg::elem_t elem0,
  input  m4rm_pkg::elem_t elem1,
  input  m4rm_pkg::elem_t elem2,
  input  m4rm_pkg::elem_t elem3,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output m4rm_pkg::elem_t prod0,
  output m4rm_pkg::elem_t prod1,
  output m4rm_pkg::elem_t prod2,
  output m4rm_pkg::elem_t prod3,
  output logic            clipped
);
  import m4rm_pkg::*;

  // stored right-hand matrix, indexed [row][column]
  elem_t mat [DIM][DIM];

  vec_t      row;
  vec_t      col [DIM];
  elem_t     prod [DIM];
  logic      clip [DIM];
  stage_en_t en;
  logic      v1, v2, v3, v4;
  logic      acc;

  assign row[0] = elem0;
  assign row[1] = elem1;
  assign row[2] = elem2;
  assign row[3] = elem3;

  // Bubble-collapsing advance: a stage moves when empty or when the next moves.
  assign en.s4     = !v4 || !rsp_stall;
  assign en.s3     = !v3 || en.s4;
  assign en.s2     = !v2 || en.s3;
  assign en.s1     = !v1 || en.s2;
  assign req_stall = !en.s1;
  assign acc       = req_valid && !req_stall;

  // Loads write M on acceptance, so a later multiply request always sees
  // every earlier load. Rows beyond DIM are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          mat[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (acc && !mode && (32'(row_index) < DIM)) begin
      mat[IDX_W'(row_index)] <= row;
    end
  end

  // column j of M feeds output column j
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      for (int k = 0; k < DIM; k++) begin
        col[j][k] = mat[k][j];
      end
    end
  end

  // valid bits ride alongside the column datapaths
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.s1) begin
        v1 <= acc && mode;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
      if (en.s4) begin
        v4 <= v3;
      end
    end
  end

  for (genvar j = 0; j < DIM; j++) begin : g_col
    m4rm_column u_col (
      .clk  (clk),
      .en   (en),
      .row  (row),
      .col  (col[j]),
      .prod (prod[j]),
      .clip (clip[j])
    );
  end

  assign rsp_valid = v4;
  assign prod0     = prod[0];
  assign prod1     = prod[1];
  assign prod2     = prod[2];
  assign prod3     = prod[3];

  always_comb begin
    clipped = 1'b0;
    for (int j = 0; j < DIM; j++) begin
      clipped = clipped | clip[j];
    end
  end

  // input held off only when every stage is full and the output is held
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (v1 && v2 && v3 && v4 && rsp_stall))
    else $error("request stalled with a free pipeline slot");

  // an accepted multiply occupies stage 1 next cycle
  a_mul_enters : assert property (@(posedge clk) disable iff (rst)
    (acc && mode) |=> v1)
    else $error("multiply request lost at entry");

  // a load never creates a result slot
  a_load_bubble : assert property (@(posedge clk) disable iff (rst)
    (acc && !mode) |=> !v1)
    else $error("load request entered the datapath");

  // reset leaves the identity in place
  a_reset_ident : assert property (@(posedge clk)
    $past(rst) |-> (mat[0][0] == ONE && mat[0][1] == '0))
    else $error("matrix not identity after reset");

endmodule

// ----- tb/sv/m4rm_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// m4rm_tb_pkg
// Request codes shared by the row-multiply stimulus and its checker.
// ----------------------------------------------------------------------------
package m4rm_tb_pkg;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_MULTIPLY = 1'b1
  } op_t;

endpackage

// ----- tb/sv/matrix4_row_multiply_checker.sv -----
// ----------------------------------------------------------------------------
// matrix4_row_multiply_checker
// Watches both channels, keeps its own copy of the stored matrix, works out
// each product row on request acceptance and compares it with the response.
// ----------------------------------------------------------------------------
module matrix4_row_multiply_checker
  import m4rm_pkg::*;
  import m4rm_tb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  logic  req_stall,
  input  logic  mode,
  input  logic  [1:0] row_index,
  input  elem_t elem0,
  input  elem_t elem1,
  input  elem_t elem2,
  input  elem_t elem3,
  input  logic  rsp_valid,
  input  logic  rsp_stall,
  input  elem_t prod0,
  input  elem_t prod1,
  input  elem_t prod2,
  input  elem_t prod3,
  input  logic  clipped,
  output int    errors,
  output int    pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACC_W = 2 * ELEM_W + 4;

  typedef struct packed {
    logic [DIM-1:0][ELEM_W-1:0] col;
    logic                       clip;
  } product_row_t;

  elem_t        stored_m [DIM][DIM];
  product_row_t product_q [$];
  int           fail_tally = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    fail_tally++;
  endtask

  // exact sum of products, floor shift, saturate
  function automatic product_row_t multiply_row(input elem_t a [DIM]);
    product_row_t            r;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shifted;
    r = '0;
    for (int j = 0; j < DIM; j++) begin
      acc = '0;
      for (int k = 0; k < DIM; k++)
        acc += ACC_W'(a[k]) * ACC_W'(stored_m[k][j]);
      shifted = acc >>> FRAC_BITS;
      if (shifted > ACC_W'(EMAX)) begin
        r.col[j] = EMAX;
        r.clip   = 1'b1;
      end else if (shifted < ACC_W'(EMIN)) begin
        r.col[j] = EMIN;
        r.clip   = 1'b1;
      end else begin
        r.col[j] = shifted[ELEM_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    elem_t        req_row [DIM];
    elem_t        rsp_row [DIM];
    product_row_t want;
    if (rst) begin
      for (int r = 0; r < DIM; r++)
        for (int c = 0; c < DIM; c++)
          stored_m[r][c] = (r == c) ? ONE : '0;
      product_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_row = '{prod0, prod1, prod2, prod3};
        if (product_q.size() == 0) begin
          report_mismatch("unexpected response", prod0, '0);
        end else begin
          want = product_q.pop_front();
          for (int j = 0; j < DIM; j++)
            if (rsp_row[j] !== elem_t'(want.col[j]))
              report_mismatch($sformatf("prod%0d", j), rsp_row[j], want.col[j]);
          if (clipped !== want.clip)
            report_mismatch("clipped", 32'(clipped), 32'(want.clip));
        end
      end
      if (req_valid && !req_stall) begin
        req_row = '{elem0, elem1, elem2, elem3};
        if (op_t'(mode) == OP_LOAD) begin
          if (int'(row_index) < DIM)
            for (int k = 0; k < DIM; k++)
              stored_m[row_index][k] = req_row[k];
        end else begin
          product_q.push_back(multiply_row(req_row));
        end
      end
    end
    errors  <= fail_tally;
    pending <= product_q.size();
  end

endmodule

// ----- tb/sv/tb_matrix4_row_multiply.sv -----
// ----------------------------------------------------------------------------
// tb_matrix4_row_multiply
// Drives load and multiply requests into the row multiplier under several
// idling and back-pressure patterns; the checker beside it does the scoring.
// ----------------------------------------------------------------------------
module tb_matrix4_row_multiply;

  timeunit 1ns;
  timeprecision 1ps;

  import m4rm_pkg::*;
  import m4rm_tb_pkg::*;

  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills the pipe
  localparam int DRAIN_CYCLES = 12;   // well past the time the pipeline takes to drain
  localparam int PHASE_ITEMS  = 350;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic        mode;
  logic [1:0]  row_index;
  elem_t       elem0, elem1, elem2, elem3;
  logic        rsp_valid;
  logic        rsp_stall;
  elem_t       prod0, prod1, prod2, prod3;
  logic        clipped;

  int          fail_count;
  int          outstanding;

  // idling knobs, the two pct ones in percent of cycles; read by the sender and receiver
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  bit          hold_go       = 1'b0;

  matrix4_row_multiply u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (mode),
    .row_index (row_index),
    .elem0     (elem0),
    .elem1     (elem1),
    .elem2     (elem2),
    .elem3     (elem3),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .prod0     (prod0),
    .prod1     (prod1),
    .prod2     (prod2),
    .prod3     (prod3),
    .clipped   (clipped)
  );

  matrix4_row_multiply_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (mode),
    .row_index (row_index),
    .elem0     (elem0),
    .elem1     (elem1),
    .elem2     (elem2),
    .elem3     (elem3),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .prod0     (prod0),
    .prod1     (prod1),
    .prod2     (prod2),
    .prod3     (prod3),
    .clipped   (clipped),
    .errors    (fail_count),
    .pending   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request and hold it until accepted. Idle cycles go first, so a
  // request already offered is never withdrawn. Returns in the time step of
  // the accepting edge, ready for the next request to be driven.
  task automatic send_req(input op_t op, input logic [1:0] idx,
                          input elem_t e0, input elem_t e1,
                          input elem_t e2, input elem_t e3);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    mode      <= op;
    row_index <= idx;
    elem0     <= e0;
    elem1     <= e1;
    elem2     <= e2;
    elem3     <= e3;
    do @(posedge clk); while (req_stall);
  endtask

  // Element mix: mostly modest Q16.16 values so that sums stay in range,
  // with full-width noise and the corner values thrown in.
  function automatic elem_t pick_elem();
    elem_t corner [5];
    corner = '{EMAX, EMIN, '0, ONE, -ONE};
    case ($urandom_range(0, 9))
      0, 1:    return elem_t'($urandom);
      2:       return corner[$urandom_range(0, 4)];
      default: return elem_t'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  // Random requests: about a quarter are row loads, the rest multiplies.
  // row_index is random on multiplies too, where it should be ignored.
  task automatic send_random(input int count);
    op_t op;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 99) < 25) ? OP_LOAD : OP_MULTIPLY;
      send_req(op, 2'($urandom_range(0, 3)),
               pick_elem(), pick_elem(), pick_elem(), pick_elem());
    end
  endtask

  // Receiver: random stalls, or a long counted hold-off when asked for.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Stimulus
  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    mode      <= OP_LOAD;
    row_index <= '0;
    elem0     <= '0;
    elem1     <= '0;
    elem2     <= '0;
    elem3     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: identity after reset passes extremes through unchanged;
    // row_index ignored.
    send_req(OP_MULTIPLY, 2'd3, EMAX, EMIN, '0, -32'sd1);
    send_req(OP_MULTIPLY, 2'd1, ONE, -ONE, 32'sh0001_8000, 32'sd1);

    // Load extreme rows
    send_req(OP_LOAD, 2'd0, EMAX, EMAX, EMAX, EMAX);
    send_req(OP_LOAD, 2'd1, EMIN, EMIN, EMIN, EMIN);
    send_req(OP_LOAD, 2'd2, ONE, ONE, ONE, ONE);
    send_req(OP_LOAD, 2'd3, 32'sd1, 32'sd1, -32'sd1, '0);

    // positive then negative saturation, then full rows of each extreme
    send_req(OP_MULTIPLY, 2'd0, EMAX, '0, '0, '0);
    send_req(OP_MULTIPLY, 2'd0, EMIN, '0, '0, '0);
    send_req(OP_MULTIPLY, 2'd2, EMAX, EMAX, EMAX, EMAX);
    send_req(OP_MULTIPLY, 2'd2, EMIN, EMIN, EMIN, EMIN);
    // huge partial products that cancel: no clip
    send_req(OP_MULTIPLY, 2'd0, EMIN, EMIN, '0, '0);
    // fraction-only sums: floor of +1 and -1 LSB
    send_req(OP_MULTIPLY, 2'd0, '0, '0, '0, 32'sd1);
    send_req(OP_MULTIPLY, 2'd0, '0, '0, '0, -32'sd1);
    send_req(OP_MULTIPLY, 2'd0, '0, '0, ONE, '0);
    send_req(OP_MULTIPLY, 2'd0, '0, '0, '0, '0);

    // back to identity, then extremes through it again
    send_req(OP_LOAD, 2'd0, ONE, '0, '0, '0);
    send_req(OP_LOAD, 2'd1, '0, ONE, '0, '0);
    send_req(OP_LOAD, 2'd2, '0, '0, ONE, '0);
    send_req(OP_LOAD, 2'd3, '0, '0, '0, ONE);
    send_req(OP_MULTIPLY, 2'd0, EMIN, EMIN, EMIN, EMIN);
    send_req(OP_MULTIPLY, 2'd0, EMAX, EMAX, EMAX, EMAX);
    send_req(OP_MULTIPLY, 2'd0, -ONE, ONE, -32'sd1, 32'sh7fff_0000);

    // Random phases: free flow, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 45; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      send_random(PHASE_ITEMS);
    end

    // Back-pressure: receiver holds off while requests keep coming, so the
    // pipe fills and the input stall must rise.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_go       = 1'b1;
    send_random(250);

    req_valid <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/m4rm_pkg.sv
hw/rtl/m4rm_column.sv
hw/rtl/matrix4_row_multiply.sv
tb/sv/m4rm_tb_pkg.sv
tb/sv/matrix4_row_multiply_checker.sv
tb/sv/tb_matrix4_row_multiply.sv
